[rtl/upd_pkg.sv]
// Shared types, character codes and hex helpers for the URL percent decoder.
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int UPD_QUEUE_DEPTH = 4;

    // Decoded bytes produced by one input word, oldest in slot 0.
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      count;
        logic            string_end;
    } upd_cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic res;
        res = ((c >= 8'h30) && (c <= 8'h39)) ||
              ((c >= 8'h41) && (c <= 8'h46)) ||
              ((c >= 8'h61) && (c <= 8'h66));
        return res;
    endfunction

    // Valid only for hex digits: letters sit at low nibble 1..6 in both cases.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] res;
        if (c[6])
        begin
            res = c[3:0] + 4'd9;
        end
        else
        begin
            res = c[3:0];
        end
        return res;
    endfunction

endpackage

[rtl/url_percent_decoder.sv]
// URL percent decoder: takes one encoded byte per cycle whenever full is low,
// with string_end on the last byte of each string, and delivers decoded bytes
// one per cycle while pop is high. "%XY" with two hex digits (either case)
// becomes one byte; a broken escape passes its '%' and digit through as
// literals; '+' becomes a space while query_mode is 1. The front end decodes
// each input byte in its accept cycle into a command of zero to three bytes
// and writes it into a QUEUE_DEPTH-entry queue; the back end moves one byte
// per cycle, unless stalled by pop, from the queue head into the output
// register. As decoding never yields more bytes than it consumes, that rate
// holds; full rises only when the queue fills because pop is held low or a
// burst of broken escapes briefly outpaces the back end. query_mode is written
// through cfg_valid and cfg_data (cfg_ready is always high); the user must
// write it only while the block is idle; the block does not enforce this.
module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int QUEUE_DEPTH = UPD_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_done,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic     query_mode_reg;
    logic     accept;
    logic     cmd_push;
    upd_cmd_t front_cmd;
    logic     q_valid;
    logic     q_pop;
    upd_cmd_t head_cmd;
    logic     q_full;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            query_mode_reg <= cfg_data;
        end
    end

    upd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .query_mode (query_mode_reg),
        .accept     (accept),
        .in_byte    (in_byte),
        .string_end (string_end),
        .cmd_push   (cmd_push),
        .cmd        (front_cmd)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_cmd   (front_cmd),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (head_cmd),
        .full     (q_full)
    );

    upd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd         (head_cmd),
        .cmd_pop     (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule

[rtl/upd_front.sv]
// Front end: tracks escape state and turns each input byte into a decode command.
module upd_front
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       query_mode,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    output logic       cmd_push,
    output upd_cmd_t   cmd
);

    typedef enum logic [1:0] {
        PH_PLAIN   = 2'd0,
        PH_PERCENT = 2'd1,
        PH_DIGIT   = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    function automatic upd_cmd_t append(input upd_cmd_t c, input logic [7:0] v);
        upd_cmd_t r;
        r = c;
        unique case (c.count)
            2'd0:    r.data[0] = v;
            2'd1:    r.data[1] = v;
            2'd2:    r.data[2] = v;
            default: r.data[2] = c.data[2];
        endcase
        if (c.count != 2'd3)
        begin
            r.count = c.count + 2'd1;
        end
        return r;
    endfunction

    always_comb
    begin
        logic       hex;
        logic [7:0] mapped;
        upd_cmd_t   c;
        hex    = is_hex(in_byte);
        mapped = (query_mode && (in_byte == CH_PLUS)) ? CH_SPACE : in_byte;
        c.data       = '0;
        c.count      = 2'd0;
        c.string_end = string_end;
        phase_next = phase_reg;
        held_next  = held_reg;
        if ((phase_reg == PH_PERCENT) && hex)
        begin
            held_next  = in_byte;
            phase_next = PH_DIGIT;
        end
        else if ((phase_reg == PH_DIGIT) && hex)
        begin
            c = append(c, {hex_val(held_reg), hex_val(in_byte)});
            phase_next = PH_PLAIN;
        end
        else
        begin
            // Broken escape: release what is pending, then treat the byte as plain.
            if ((phase_reg == PH_PERCENT) || (phase_reg == PH_DIGIT))
            begin
                c = append(c, CH_PERCENT);
            end
            if (phase_reg == PH_DIGIT)
            begin
                c = append(c, held_reg);
            end
            if (in_byte == CH_PERCENT)
            begin
                phase_next = PH_PERCENT;
            end
            else
            begin
                c = append(c, mapped);
                phase_next = PH_PLAIN;
            end
        end
        if (string_end)
        begin
            // Flush any pending escape at the end of the string.
            if ((phase_next == PH_PERCENT) || (phase_next == PH_DIGIT))
            begin
                c = append(c, CH_PERCENT);
            end
            if (phase_next == PH_DIGIT)
            begin
                c = append(c, held_next);
            end
            phase_next = PH_PLAIN;
        end
        cmd      = c;
        cmd_push = accept && (c.count != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PLAIN;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

[rtl/upd_queue.sv]
// Short command queue between the front end and the back end.
module upd_queue
    import upd_pkg::*;
#(
    parameter int DEPTH = UPD_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  upd_cmd_t wr_cmd,
    input  logic     rd_en,
    output logic     rd_valid,
    output upd_cmd_t rd_cmd,
    output logic     full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    upd_cmd_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign rd_valid = (count_reg != '0);
    assign full     = (count_reg == FULL_CNT);
    assign rd_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/upd_back.sv]
// Back end: walks the bytes of each command into the output register.
module upd_back
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  upd_cmd_t   cmd,
    output logic       cmd_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_done
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       string_done_reg;
    logic       load;
    logic       last;
    logic [7:0] sel_byte;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = cmd.data[0];
            2'd1:    sel_byte = cmd.data[1];
            default: sel_byte = cmd.data[2];
        endcase
    end

    assign load    = cmd_valid && (!out_valid_reg || pop);
    assign last    = (idx_reg == (cmd.count - 2'd1));
    assign cmd_pop = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg    <= sel_byte;
            run_last_reg    <= last;
            string_done_reg <= last && cmd.string_end;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign string_done = string_done_reg;

endmodule

[rtl/upd_checker.sv]
// Port-level checks for the URL percent decoder, bound to the top level.
module upd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       string_done,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // A waiting word stays until popped.
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result word dropped without pop");

    a_stable_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(out_byte) && $stable(run_last) &&
                              $stable(string_done)))
        else $error("result word changed while stalled");

    // The end of a string is always the end of that byte's run.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && string_done) |-> run_last)
        else $error("string_done without run_last");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);
